// ----- design/nsb_pkg.sv -----
package nsb_pkg;

	localparam int IMAGE_BYTES     = 4096;
	localparam int PALETTE_ENTRIES = 256;
	localparam int BITS_PER_PIXEL  = 4;

	localparam int CW         = 12;
	localparam int MOD_STAGES = CW;
	localparam int IMG_AW     = $clog2(IMAGE_BYTES);
	localparam int PAL_AW     = $clog2(PALETTE_ENTRIES);
	localparam int PIX_W      = 2 * CW + 1;
	localparam int BIT_W      = PIX_W + 4;
	localparam int BYTE_W     = BIT_W - 3;

	typedef enum logic [1:0] {
		CMD_LOAD_IMG = 2'd0,
		CMD_LOAD_PAL = 2'd1,
		CMD_SHADE    = 2'd2,
		CMD_NOP      = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		CFG_DEST_W   = 3'd0,
		CFG_DEST_H   = 3'd1,
		CFG_SRC_W    = 3'd2,
		CFG_SRC_H    = 3'd3,
		CFG_SLICE_L  = 3'd4,
		CFG_SLICE_T  = 3'd5,
		CFG_SLICE_R  = 3'd6,
		CFG_SLICE_B  = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		AX_LO  = 2'd0,
		AX_MID = 2'd1,
		AX_HI  = 2'd2
	} axcls_t;

	typedef struct packed {
		axcls_t             cls;
		logic signed [13:0] pre;
		logic [CW-1:0]      num;
		logic               empty;
	} axis_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [CW-1:0]      addr;
		logic [31:0]        word;
		logic [31:0]        dst;
		logic               kill;
		logic               bad;
		axcls_t             xcls;
		axcls_t             ycls;
		logic signed [13:0] xpre;
		logic signed [13:0] ypre;
	} item_t;

	// border columns map straight, far border maps from the source's far edge,
	// center gets its offset reduced later by the modulo pipe
	function automatic axis_t axis_dec(logic [CW-1:0] p, logic [CW-1:0] d,
			logic [CW-1:0] s, logic [CW-1:0] lo, logic [CW-1:0] hi);
		axis_t              r;
		logic signed [13:0] cw;
		cw      = $signed({2'b0, s}) - $signed({2'b0, lo}) - $signed({2'b0, hi});
		r.num   = p - lo;
		r.empty = 1'b0;
		r.pre   = '0;
		if (p < lo) begin
			r.cls = AX_LO;
			r.pre = $signed({2'b0, p});
		end else if ({1'b0, p} >= ({1'b0, d} - {1'b0, hi})) begin
			r.cls = AX_HI;
			r.pre = $signed({2'b0, s}) - $signed({2'b0, d}) + $signed({2'b0, p});
		end else begin
			r.cls   = AX_MID;
			r.empty = (cw <= 14'sd0);
		end
		return r;
	endfunction

	// x / 255 for x < 65280
	function automatic logic [7:0] div255(logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
		return t[15:8];
	endfunction

endpackage

// ----- design/nsb_if.sv -----
interface nsb_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [11:0] load_addr;
	logic [31:0] load_word;
	logic [11:0] rel_x;
	logic [11:0] rel_y;
	logic [31:0] dst_color;

	modport source(output valid, cmd, load_addr, load_word, rel_x, rel_y, dst_color,
		input ready);
	modport sink(input valid, cmd, load_addr, load_word, rel_x, rel_y, dst_color,
		output ready);
endinterface

interface nsb_out_if;
	logic        valid;
	logic        ready;
	logic        write_pixel;
	logic [31:0] out_color;
	logic        bad_setup;

	modport source(output valid, write_pixel, out_color, bad_setup, input ready);
	modport sink(input valid, write_pixel, out_color, bad_setup, output ready);
endinterface

// ----- design/nine_slice_palette_alpha_blit.sv -----
// An accepted input transaction passes the decode register, the modulo stages and s14 to s19 to out_ch.
// Throughput: one transaction per cycle; the whole pipeline advances together
// and holds while the output register is full and not taken.
// The center modulo is a 12-stage restoring remainder pipe, one bit per stage.
// arst_n clears valid bits and configuration registers; stores are not cleared.
module nine_slice_palette_alpha_blit import nsb_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	nsb_in_if.sink          in_ch,
	nsb_out_if.source       out_ch,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_idx,
	input  logic [CW-1:0]   cfg_wdata
);

	logic [CW-1:0] dw_q, dh_q, sw_q, sh_q, sl_q, st_q, sr_q, sb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dw_q <= '0; dh_q <= '0; sw_q <= '0; sh_q <= '0;
			sl_q <= '0; st_q <= '0; sr_q <= '0; sb_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_DEST_W:  dw_q <= cfg_wdata;
				CFG_DEST_H:  dh_q <= cfg_wdata;
				CFG_SRC_W:   sw_q <= cfg_wdata;
				CFG_SRC_H:   sh_q <= cfg_wdata;
				CFG_SLICE_L: sl_q <= cfg_wdata;
				CFG_SLICE_T: st_q <= cfg_wdata;
				CFG_SLICE_R: sr_q <= cfg_wdata;
				CFG_SLICE_B: sb_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic en;
	logic v_s19;
	assign en          = !v_s19 || out_ch.ready;
	assign in_ch.ready = en;

	// ---- decode ----
	axis_t ax, ay;
	item_t dec;
	logic  outside, overlap;

	always_comb begin
		ax      = axis_dec(in_ch.rel_x, dw_q, sw_q, sl_q, sr_q);
		ay      = axis_dec(in_ch.rel_y, dh_q, sh_q, st_q, sb_q);
		outside = (in_ch.rel_x >= dw_q) || (in_ch.rel_y >= dh_q);
		overlap = ({1'b0, sl_q} + {1'b0, sr_q} > {1'b0, dw_q}) ||
			({1'b0, st_q} + {1'b0, sb_q} > {1'b0, dh_q});
		dec.cmd  = in_ch.cmd;
		dec.addr = in_ch.load_addr;
		dec.word = in_ch.load_word;
		dec.dst  = in_ch.dst_color;
		dec.xcls = ax.cls;
		dec.ycls = ay.cls;
		dec.xpre = ax.pre;
		dec.ypre = ay.pre;
		dec.kill = 1'b1;
		dec.bad  = 1'b0;
		case (cmd_t'(in_ch.cmd))
			CMD_LOAD_IMG: dec.bad = !(32'(in_ch.load_addr) < IMAGE_BYTES);
			CMD_LOAD_PAL: dec.bad = !(32'(in_ch.load_addr) < PALETTE_ENTRIES);
			CMD_SHADE: begin
				if (outside) begin
					dec.bad = 1'b0;
				end else if (overlap || (ax.cls == AX_MID && ax.empty) ||
						(ay.cls == AX_MID && ay.empty)) begin
					dec.bad = 1'b1;
				end else begin
					dec.kill = 1'b0;
				end
			end
			default: ;
		endcase
	end

	logic  v_s1;
	item_t it_s1;
	logic [CW-1:0] xnum_s1, ynum_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1   <= dec;
			xnum_s1 <= ax.num;
			ynum_s1 <= ay.num;
		end
	end

	// ---- modulo stages, item rides alongside ----
	logic [CW-1:0] cx, cy, xrem, yrem;
	logic signed [13:0] cxw, cyw;
	assign cxw = $signed({2'b0, sw_q}) - $signed({2'b0, sl_q}) - $signed({2'b0, sr_q});
	assign cyw = $signed({2'b0, sh_q}) - $signed({2'b0, st_q}) - $signed({2'b0, sb_q});
	assign cx  = cxw[CW-1:0];
	assign cy  = cyw[CW-1:0];

	nsb_mod_pipe u_modx (.clk(clk), .en(en), .num(xnum_s1), .div(cx), .rem(xrem));
	nsb_mod_pipe u_mody (.clk(clk), .en(en), .num(ynum_s1), .div(cy), .rem(yrem));

	item_t it_md_s [MOD_STAGES];
	logic  v_md_s  [MOD_STAGES];

	always_ff @(posedge clk) begin
		if (en) begin
			it_md_s[0] <= it_s1;
			for (int k = 1; k < MOD_STAGES; k++)
				it_md_s[k] <= it_md_s[k-1];
		end
	end

	// ---- source position and bounds ----
	logic signed [13:0] sx, sy;
	logic               src_out;
	item_t              it14_d;
	always_comb begin
		sx = (it_md_s[MOD_STAGES-1].xcls == AX_MID) ?
			$signed({2'b0, sl_q}) + $signed({2'b0, xrem}) : it_md_s[MOD_STAGES-1].xpre;
		sy = (it_md_s[MOD_STAGES-1].ycls == AX_MID) ?
			$signed({2'b0, st_q}) + $signed({2'b0, yrem}) : it_md_s[MOD_STAGES-1].ypre;
		src_out = (sx < 14'sd0) || (sx >= $signed({2'b0, sw_q})) ||
			(sy < 14'sd0) || (sy >= $signed({2'b0, sh_q}));
		it14_d = it_md_s[MOD_STAGES-1];
		if (src_out)
			it14_d.kill = 1'b1;
	end

	logic  v_s14;
	item_t it_s14;
	logic [CW-1:0] sx_s14, sy_s14;
	always_ff @(posedge clk) begin
		if (en) begin
			it_s14      <= it14_d;
			sx_s14      <= sx[CW-1:0];
			sy_s14      <= sy[CW-1:0];
		end
	end

	logic  v_s15;
	item_t it_s15;
	logic [CW-1:0]   sx_s15;
	logic [2*CW-1:0] prod_s15;
	always_ff @(posedge clk) begin
		if (en) begin
			it_s15   <= it_s14;
			sx_s15   <= sx_s14;
			prod_s15 <= sy_s14 * sw_q;
		end
	end

	// ---- image address, image store ----
	logic [PIX_W-1:0]  pix;
	logic [BIT_W-1:0]  bitpos;
	logic [BYTE_W-1:0] byte_a, byte_b;
	logic [2:0]        off;
	logic              strad, img_oob;
	item_t             it16_d;
	always_comb begin
		pix     = PIX_W'(prod_s15) + PIX_W'(sx_s15);
		bitpos  = BIT_W'(pix) * BIT_W'(BITS_PER_PIXEL);
		byte_a  = bitpos[BIT_W-1:3];
		byte_b  = byte_a + BYTE_W'(1);
		off     = bitpos[2:0];
		strad   = ({1'b0, off} + 4'(BITS_PER_PIXEL)) > 4'd8;
		img_oob = (32'(byte_a) >= IMAGE_BYTES) || (strad && (32'(byte_b) >= IMAGE_BYTES));
		it16_d  = it_s15;
		if (!it_s15.kill && img_oob) begin
			it16_d.kill = 1'b1;
			it16_d.bad  = 1'b1;
		end
	end

	logic [7:0] img_mem [IMAGE_BYTES];
	logic  v_s16;
	item_t it_s16;
	logic [7:0] rd0_s16, rd1_s16;
	logic [2:0] off_s16;
	logic       strad_s16;
	always_ff @(posedge clk) begin
		if (en) begin
			if (v_s15 && it_s15.cmd == CMD_LOAD_IMG && !it_s15.bad)
				img_mem[IMG_AW'(it_s15.addr)] <= it_s15.word[7:0];
			rd0_s16   <= img_mem[byte_a[IMG_AW-1:0]];
			rd1_s16   <= img_mem[byte_b[IMG_AW-1:0]];
			off_s16   <= off;
			strad_s16 <= strad;
			it_s16    <= it16_d;
		end
	end

	// ---- index unpack, palette ----
	logic [15:0]               win;
	logic [BITS_PER_PIXEL-1:0] idx;
	logic [8:0]                idx9;
	item_t                     it17_d;
	always_comb begin
		win  = {rd0_s16, strad_s16 ? rd1_s16 : 8'd0};
		idx  = BITS_PER_PIXEL'(win >> (5'd16 - 5'(BITS_PER_PIXEL) - {2'b0, off_s16}));
		idx9 = 9'(idx);
		it17_d = it_s16;
		if (!it_s16.kill && !(32'(idx9) < PALETTE_ENTRIES)) begin
			it17_d.kill = 1'b1;
			it17_d.bad  = 1'b1;
		end
	end

	logic [31:0] pal_mem [PALETTE_ENTRIES];
	logic  v_s17;
	item_t it_s17;
	logic [31:0] pe_s17;
	always_ff @(posedge clk) begin
		if (en) begin
			if (v_s16 && it_s16.cmd == CMD_LOAD_PAL && !it_s16.bad)
				pal_mem[PAL_AW'(it_s16.addr)] <= it_s16.word;
			pe_s17 <= pal_mem[idx9[PAL_AW-1:0]];
			it_s17 <= it17_d;
		end
	end

	// ---- blend: products, then sum and /255 ----
	logic  v_s18;
	item_t it_s18;
	logic [15:0] ps_s18 [3];
	logic [15:0] pd_s18 [3];
	logic [7:0]  ia;
	assign ia = 8'd255 - pe_s17[31:24];
	always_ff @(posedge clk) begin
		if (en) begin
			it_s18    <= it_s17;
			ps_s18[0] <= pe_s17[7:0]   * pe_s17[31:24];
			ps_s18[1] <= pe_s17[15:8]  * pe_s17[31:24];
			ps_s18[2] <= pe_s17[23:16] * pe_s17[31:24];
			pd_s18[0] <= it_s17.dst[23:16] * ia;
			pd_s18[1] <= it_s17.dst[15:8]  * ia;
			pd_s18[2] <= it_s17.dst[7:0]   * ia;
		end
	end

	logic        wr_s19, bad_s19;
	logic [31:0] col_s19;
	always_ff @(posedge clk) begin
		if (en) begin
			wr_s19  <= !it_s18.kill;
			bad_s19 <= it_s18.bad;
			col_s19 <= it_s18.kill ? 32'd0 :
				{8'hFF, div255(ps_s18[0] + pd_s18[0]), div255(ps_s18[1] + pd_s18[1]),
				div255(ps_s18[2] + pd_s18[2])};
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			for (int k = 0; k < MOD_STAGES; k++)
				v_md_s[k] <= 1'b0;
			v_s14 <= 1'b0; v_s15 <= 1'b0; v_s16 <= 1'b0;
			v_s17 <= 1'b0; v_s18 <= 1'b0; v_s19 <= 1'b0;
		end else if (en) begin
			v_s1      <= in_ch.valid;
			v_md_s[0] <= v_s1;
			for (int k = 1; k < MOD_STAGES; k++)
				v_md_s[k] <= v_md_s[k-1];
			v_s14 <= v_md_s[MOD_STAGES-1];
			v_s15 <= v_s14;
			v_s16 <= v_s15;
			v_s17 <= v_s16;
			v_s18 <= v_s17;
			v_s19 <= v_s18;
		end
	end

	assign out_ch.valid       = v_s19;
	assign out_ch.write_pixel = wr_s19;
	assign out_ch.out_color   = col_s19;
	assign out_ch.bad_setup   = bad_s19;

endmodule

// ----- design/nsb_mod_pipe.sv -----
module nsb_mod_pipe import nsb_pkg::*; (
	input  logic          clk,
	input  logic          en,
	input  logic [CW-1:0] num,
	input  logic [CW-1:0] div,
	output logic [CW-1:0] rem
);

	logic [CW-1:0] rem_s [MOD_STAGES];
	logic [CW-1:0] num_s [MOD_STAGES];

	// restoring remainder, one dividend bit per stage, MSB first
	function automatic logic [CW-1:0] rstep(logic [CW-1:0] r, logic b, logic [CW-1:0] d);
		logic [CW:0] t;
		t = {r, b};
		if (t >= {1'b0, d})
			t = t - {1'b0, d};
		return t[CW-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= rstep('0, num[CW-1], div);
			num_s[0] <= num;
			for (int k = 1; k < MOD_STAGES; k++) begin
				rem_s[k] <= rstep(rem_s[k-1], num_s[k-1][CW-1-k], div);
				num_s[k] <= num_s[k-1];
			end
		end
	end

	assign rem = rem_s[MOD_STAGES-1];

endmodule

// ----- verif/nine_slice_palette_alpha_blit_test.sv -----
`timescale 1ns / 1ps

module nine_slice_palette_alpha_blit_test;
	import nsb_pkg::*;

	typedef struct packed {
		logic        wr;
		logic [31:0] color;
		logic        bad;
	} pix_res_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [11:0] addr;
		logic [31:0] word;
		logic [11:0] x;
		logic [11:0] y;
		logic [31:0] dst;
	} pix_req_t;

	typedef struct packed {
		logic       is_cfg;
		cfg_idx_t   idx;
		logic [11:0] val;
		pix_req_t   req;
		logic       typed;
		pix_res_t   res;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [11:0] cfg_wdata;

	nsb_in_if  in_ch();
	nsb_out_if out_ch();

	nine_slice_palette_alpha_blit dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	// shadow of the block's registers and stores
	logic [11:0] geom[8];
	logic [7:0]  img_mem[IMAGE_BYTES];
	bit          img_ok[IMAGE_BYTES];
	logic [31:0] pal_mem[PALETTE_ENTRIES];
	bit          pal_ok[PALETTE_ENTRIES];

	pix_res_t pixq[$];
	int       mismatches;
	int       n_checked;
	int       n_written;
	int       n_flagged;
	bit       steady;
	dir_row_t rows[$];

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic bit map_axis(longint p, longint d, longint s, longint lo, longint hi,
			output longint src);
		longint c;
		c = s - lo - hi;
		src = 0;
		if (p < lo) src = p;
		else if (p >= d - hi) src = s - hi + (p - (d - hi));
		else begin
			if (c <= 0) return 1'b0;
			src = lo + (p - lo) % c;
		end
		return 1'b1;
	endfunction

	function automatic logic [7:0] mix(logic [7:0] s, logic [7:0] d, logic [7:0] a);
		int unsigned v;
		v = (s * a + d * (255 - a)) / 255;
		return v[7:0];
	endfunction

	// unsafe: the pixel would read a store entry never written
	function automatic pix_res_t shade_pixel(pix_req_t q, output bit unsafe);
		pix_res_t    res;
		longint      sx, sy, bitpos, byte_a;
		logic [15:0] win;
		logic [3:0]  idx;
		logic [31:0] pe;
		res = '0;
		unsafe = 1'b0;
		if (q.x >= geom[CFG_DEST_W] || q.y >= geom[CFG_DEST_H]) return res;
		if ({1'b0, geom[CFG_SLICE_L]} + {1'b0, geom[CFG_SLICE_R]} > {1'b0, geom[CFG_DEST_W]} ||
				{1'b0, geom[CFG_SLICE_T]} + {1'b0, geom[CFG_SLICE_B]} >
				{1'b0, geom[CFG_DEST_H]}) begin
			res.bad = 1'b1;
			return res;
		end
		if (!map_axis(q.x, geom[CFG_DEST_W], geom[CFG_SRC_W], geom[CFG_SLICE_L],
				geom[CFG_SLICE_R], sx) ||
				!map_axis(q.y, geom[CFG_DEST_H], geom[CFG_SRC_H], geom[CFG_SLICE_T],
				geom[CFG_SLICE_B], sy)) begin
			res.bad = 1'b1;
			return res;
		end
		if (sx < 0 || sx >= geom[CFG_SRC_W] || sy < 0 || sy >= geom[CFG_SRC_H]) return res;
		bitpos = (sy * geom[CFG_SRC_W] + sx) * BITS_PER_PIXEL;
		byte_a = bitpos / 8;
		if (byte_a >= IMAGE_BYTES) begin
			res.bad = 1'b1;
			return res;
		end
		win = {img_mem[byte_a], 8'h00};
		idx = 4'(win >> (16 - BITS_PER_PIXEL - bitpos % 8));
		pe = pal_mem[idx];
		unsafe = !img_ok[byte_a] || !pal_ok[idx];
		res.wr = 1'b1;
		res.color = {8'hFF, mix(pe[7:0], q.dst[23:16], pe[31:24]),
			mix(pe[15:8], q.dst[15:8], pe[31:24]), mix(pe[23:16], q.dst[7:0], pe[31:24])};
		return res;
	endfunction

	// result of an accepted transaction; loads update the shadow stores
	function automatic pix_res_t predict_and_update(pix_req_t q);
		pix_res_t res;
		bit       unsafe;
		res = '0;
		case (q.cmd)
			CMD_LOAD_IMG: begin
				img_mem[q.addr] = q.word[7:0];
				img_ok[q.addr] = 1'b1;
			end
			CMD_LOAD_PAL: begin
				if (q.addr < PALETTE_ENTRIES) begin
					pal_mem[q.addr] = q.word;
					pal_ok[q.addr] = 1'b1;
				end else res.bad = 1'b1;
			end
			CMD_SHADE: res = shade_pixel(q, unsafe);
			default: ;
		endcase
		return res;
	endfunction

	task automatic send_pixel(pix_req_t q, bit typed, pix_res_t typed_res);
		int       gap;
		pix_res_t res;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.cmd <= q.cmd;
		in_ch.load_addr <= q.addr;
		in_ch.load_word <= q.word;
		in_ch.rel_x <= q.x;
		in_ch.rel_y <= q.y;
		in_ch.dst_color <= q.dst;
		do @(posedge clk); while (!in_ch.ready);
		res = predict_and_update(q);
		pixq.push_back(typed ? typed_res : res);
	endtask

	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pixq.size() != 0) @(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	task automatic write_geom(cfg_idx_t idx, int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= 12'(val);
		geom[idx] = 12'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic pix_req_t mk_req(cmd_t c, int addr, logic [31:0] word, int x, int y,
			logic [31:0] dst);
		pix_req_t q;
		q.cmd = c;
		q.addr = 12'(addr);
		q.word = word;
		q.x = 12'(x);
		q.y = 12'(y);
		q.dst = dst;
		return q;
	endfunction

	function automatic void add_item(pix_req_t q, bit typed = 1'b0, pix_res_t r = '0);
		dir_row_t d;
		d = '0;
		d.req = q;
		d.typed = typed;
		d.res = r;
		rows.push_back(d);
	endfunction

	function automatic void add_cfg(cfg_idx_t idx, int val);
		dir_row_t d;
		d = '0;
		d.is_cfg = 1'b1;
		d.idx = idx;
		d.val = 12'(val);
		rows.push_back(d);
	endfunction

	function automatic pix_req_t rand_shade(int lim_x, int lim_y);
		return mk_req(CMD_SHADE, $urandom_range(0, 4095), $urandom,
			$urandom_range(0, lim_x), $urandom_range(0, lim_y), $urandom);
	endfunction

	function automatic pix_req_t rand_item();
		pix_req_t q;
		bit       unsafe;
		int       k, lx, ly;
		k = $urandom_range(0, 99);
		lx = geom[CFG_DEST_W] > 60 ? 60 : geom[CFG_DEST_W] + 1;
		ly = geom[CFG_DEST_H] > 60 ? 60 : geom[CFG_DEST_H] + 1;
		if (k < 70) q = rand_shade(lx, ly);
		else if (k < 78) q = mk_req(CMD_LOAD_IMG, ($urandom_range(0, 9) == 0) ?
			$urandom_range(0, 4095) : $urandom_range(0, 199), $urandom, $urandom, $urandom,
			$urandom);
		else if (k < 86) q = mk_req(CMD_LOAD_PAL, ($urandom_range(0, 3) == 0) ?
			$urandom_range(0, 4095) : $urandom_range(0, 15), $urandom, $urandom, $urandom,
			$urandom);
		else q = mk_req(cmd_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
			$urandom, $urandom);
		for (int t = 0; t < 20 && q.cmd == CMD_SHADE; t++) begin
			void'(shade_pixel(q, unsafe));
			if (!unsafe) return q;
			q = rand_shade(lx, ly);
		end
		if (q.cmd == CMD_SHADE) q.cmd = CMD_NOP;
		return q;
	endfunction

	task automatic preload(int nbytes);
		for (int i = 0; i < 16; i++)
			send_pixel(mk_req(CMD_LOAD_PAL, i, $urandom, $urandom, $urandom, $urandom),
				1'b0, '0);
		for (int i = 0; i < nbytes; i++)
			send_pixel(mk_req(CMD_LOAD_IMG, i, $urandom, $urandom, $urandom, $urandom),
				1'b0, '0);
	endtask

	// receiver: random stalls, plus one long hold-off to back up the pipeline
	initial begin
		int cyc;
		int g;
		bit held;
		cyc = 0;
		held = 1'b0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (!held && cyc >= 1500) begin
				held = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (300) @(negedge clk);
				cyc += 300;
			end
			g = pick_gap();
			out_ch.ready <= 1'b1;
			if (g > 0) begin
				@(negedge clk);
				out_ch.ready <= 1'b0;
				repeat (g - 1) @(negedge clk);
				cyc += g;
			end
		end
	end

	always @(posedge clk) begin
		pix_res_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pixq.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction wr=%0b color=%h bad=%0b",
						out_ch.write_pixel, out_ch.out_color, out_ch.bad_setup);
			end else begin
				e = pixq.pop_front();
				n_checked++;
				if (e.wr) n_written++;
				if (e.bad) n_flagged++;
				if (out_ch.write_pixel !== e.wr || out_ch.out_color !== e.color ||
						out_ch.bad_setup !== e.bad) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch #%0d: exp %0b/%h/%0b got %0b/%h/%0b",
							n_checked, e.wr, e.color, e.bad, out_ch.write_pixel,
							out_ch.out_color, out_ch.bad_setup);
				end
			end
		end
	end

	initial begin
		int sw, sh;
		mismatches = 0;
		n_checked = 0;
		n_written = 0;
		n_flagged = 0;
		steady = 1'b0;
		for (int i = 0; i < 8; i++) geom[i] = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_DEST_W;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_NOP;
		in_ch.load_addr = '0;
		in_ch.load_word = '0;
		in_ch.rel_x = '0;
		in_ch.rel_y = '0;
		in_ch.dst_color = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// geometry is all zero after reset: every pixel lies outside
		add_item(mk_req(CMD_SHADE, 0, 0, 0, 0, 0), 1'b1, '0);
		add_item(mk_req(CMD_LOAD_PAL, 4095, 32'hFFFFFFFF, 0, 0, 0), 1'b1,
			'{1'b0, 32'd0, 1'b1});
		add_item(mk_req(CMD_NOP, 4095, 32'hFFFFFFFF, 4095, 4095, 32'hFFFFFFFF), 1'b1, '0);
		add_item(mk_req(CMD_LOAD_IMG, 4095, 32'hFFFFFFFF, 4095, 4095, 0), 1'b1, '0);
		add_item(mk_req(CMD_LOAD_PAL, 0, 32'h00000000, 0, 0, 0));
		add_item(mk_req(CMD_LOAD_PAL, 15, 32'hFFFFFFFF, 0, 0, 0));
		add_cfg(CFG_DEST_W, 8);
		add_cfg(CFG_DEST_H, 8);
		add_cfg(CFG_SRC_W, 6);
		add_cfg(CFG_SRC_H, 6);
		add_cfg(CFG_SLICE_L, 2);
		add_cfg(CFG_SLICE_T, 2);
		add_cfg(CFG_SLICE_R, 2);
		add_cfg(CFG_SLICE_B, 2);
		add_item(mk_req(CMD_SHADE, 0, 0, 0, 0, 32'hFFFFFFFF));
		add_item(mk_req(CMD_SHADE, 0, 0, 7, 7, 32'h00000000));
		add_item(mk_req(CMD_SHADE, 0, 0, 3, 0, 32'h12345678));
		add_item(mk_req(CMD_SHADE, 0, 0, 5, 3, 32'h80FF0080));
		add_item(mk_req(CMD_SHADE, 0, 0, 0, 4, 32'hFF00FF00));
		add_item(mk_req(CMD_SHADE, 0, 0, 8, 0, 32'hFFFFFFFF), 1'b1, '0);
		add_item(mk_req(CMD_SHADE, 0, 0, 0, 8, 32'hFFFFFFFF), 1'b1, '0);
		// center columns vanish when the source is no wider than both slices
		add_cfg(CFG_SRC_W, 4);
		add_item(mk_req(CMD_SHADE, 0, 0, 3, 3, 0), 1'b1, '{1'b0, 32'd0, 1'b1});
		add_item(mk_req(CMD_SHADE, 0, 0, 0, 0, 0));
		// slices wider than the rectangle
		add_cfg(CFG_SLICE_L, 7);
		add_item(mk_req(CMD_SHADE, 0, 0, 0, 0, 0), 1'b1, '{1'b0, 32'd0, 1'b1});

		preload(32);
		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				drain();
				write_geom(rows[i].idx, int'(rows[i].val));
			end else send_pixel(rows[i].req, rows[i].typed, rows[i].res);
		end

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			steady = (ph % 3 == 1);
			if (ph == 5) begin
				// largest rectangle and source, far slices spanning it all
				sw = 4095;
				sh = 4095;
				write_geom(CFG_DEST_W, 4095);
				write_geom(CFG_DEST_H, 4095);
				write_geom(CFG_SLICE_L, 0);
				write_geom(CFG_SLICE_T, 0);
				write_geom(CFG_SLICE_R, 4095);
				write_geom(CFG_SLICE_B, 4095);
			end else if (ph == 6) begin
				sw = 4095;
				sh = 4095;
				for (int i = 0; i < 8; i++) write_geom(cfg_idx_t'(i), 4095);
			end else begin
				sw = $urandom_range(1, 20);
				sh = $urandom_range(1, 20);
				write_geom(CFG_DEST_W, $urandom_range(1, 40));
				write_geom(CFG_DEST_H, $urandom_range(1, 40));
				write_geom(CFG_SLICE_L, ph == 0 ? 0 : $urandom_range(0, 6));
				write_geom(CFG_SLICE_T, ph == 0 ? 0 : $urandom_range(0, 6));
				write_geom(CFG_SLICE_R, ph == 0 ? 0 : $urandom_range(0, 6));
				write_geom(CFG_SLICE_B, ph == 0 ? 0 : $urandom_range(0, 6));
			end
			write_geom(CFG_SRC_W, sw);
			write_geom(CFG_SRC_H, sh);
			preload(sw * sh > 400 ? 200 : (sw * sh + 1) / 2);
			repeat (55) send_pixel(rand_item(), 1'b0, '0);
		end

		drain();
		$display("checked %0d result transactions: %0d pixels written, %0d setup flags",
			n_checked, n_written, n_flagged);
		$display("covered corners, edges, tiled center, empty center, overlap, store bounds");
		if (mismatches == 0 && pixq.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- files.f -----
design/nsb_pkg.sv
design/nsb_if.sv
design/nsb_mod_pipe.sv
design/nine_slice_palette_alpha_blit.sv
verif/nine_slice_palette_alpha_blit_test.sv
